FILE: design/mxfp4_pkg.sv
// ----------------------------------------------------------------------------
// mxfp4_pkg
// Shared types, constants and the E2M1 x E8M0 encode function.
// ----------------------------------------------------------------------------
package mxfp4_pkg;

    localparam int unsigned BYTES_PER_BLOCK = 17;
    localparam int unsigned HALF_ELEMS      = 16;

    typedef logic [3:0]  code_t;
    typedef logic [31:0] fp32_t;

    typedef enum logic [1:0] {
        ST_STREAM,
        ST_FLUSH
    } mode_t;

    function automatic logic [3:0] code_mag(input code_t code);
        logic [3:0] m;
        case (code[2:0])
            3'd0:    m = 4'd0;
            3'd1:    m = 4'd1;
            3'd2:    m = 4'd2;
            3'd3:    m = 4'd3;
            3'd4:    m = 4'd4;
            3'd5:    m = 4'd6;
            3'd6:    m = 4'd8;
            default: m = 4'd12;
        endcase
        return m;
    endfunction

    function automatic fp32_t encode_product(input logic [7:0] scale, input code_t code);
        logic [3:0]  m;
        logic [1:0]  h;
        logic [9:0]  biased;
        logic        sign;
        fp32_t       bits;
        m    = code_mag(code);
        sign = (code >= 4'd9);
        if (m[3])      h = 2'd3;
        else if (m[2]) h = 2'd2;
        else if (m[1]) h = 2'd1;
        else           h = 2'd0;
        // biased = scale - 1 + h
        biased = {2'b00, scale} + {8'd0, h} - 10'd1;
        if (m == 4'd0)
        begin
            bits = 32'd0;
        end
        else if (!biased[9] && biased >= 10'd255)
        begin
            bits = {sign, 31'h7F800000};
        end
        else if (!biased[9] && biased != 10'd0)
        begin
            bits = {sign, biased[7:0], 23'(({19'd0, m} << (5'd23 - {3'd0, h})))};
        end
        else
        begin
            bits = {sign, 31'(({27'd0, m} << (scale[0] ? 5'd22 : 5'd21)))};
        end
        return bits;
    endfunction

endpackage

FILE: design/mxfp4_upper_ram.sv
// ----------------------------------------------------------------------------
// mxfp4_upper_ram
// 16 x 4 high-nibble store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mxfp4_upper_ram (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [3:0]          wr_addr,
    input  mxfp4_pkg::code_t    wr_data,
    input  logic                rd_en,
    input  logic [3:0]          rd_addr,
    output mxfp4_pkg::code_t    rd_data
);
    import mxfp4_pkg::*;

    code_t mem [16];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/mxfp4_block_dequantizer_core.sv
// ----------------------------------------------------------------------------
// mxfp4_block_dequantizer_core
// MXFP4 block dequantizer: byte stream in, binary32 elements out.
// ----------------------------------------------------------------------------
// Input s_axis carries one byte per transfer; blocks are 17 bytes, the E8M0
// scale first, then sixteen bytes of two E2M1 codes. Output m_axis carries
// one element per transfer with its index in tuser and block_last in tlast.
// A data byte yields its low-nibble element in the cycle after the transfer;
// high nibbles go into a 16-entry RAM and are read back after the last data
// byte, one per cycle unless the output stalls, via its registered read port.
// At most one element leaves per cycle; scale and data bytes are taken in
// consecutive cycles while the output register is free or being drained.
// The flush holds the input through sixteen RAM reads and the transfer of
// the last read element.
// Reset clears position, scale, mode and output valid; the RAM is not cleared
// since every entry is written before the flush reads it.
// When an element waits and m_axis_tready is low, the output register holds
// and s_axis_tready drops.
// ----------------------------------------------------------------------------
module mxfp4_block_dequantizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] packed_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_bits
    output logic [4:0]  m_axis_tuser,   // [4:0] element_index
    output logic        m_axis_tlast    // block_last
);
    import mxfp4_pkg::*;

    logic [4:0]  pos_reg;
    logic [7:0]  scale_reg;
    mode_t       mode_reg;
    logic [3:0]  rd_idx_reg;
    logic        rd_pend_reg;
    logic [3:0]  rd_elem_reg;
    logic        ovalid_reg;
    fp32_t       odata_reg;
    logic [4:0]  oidx_reg;
    code_t       rd_data;

    logic out_free, s_fire, is_scale, last_data, rd_en;

    // rd_pend_reg output must be consumed; fetch next only if slot will be free
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (mode_reg == ST_STREAM) && out_free && !rd_pend_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign is_scale      = (pos_reg == 5'd0) || (pos_reg >= 5'(BYTES_PER_BLOCK));
    assign last_data     = (pos_reg == 5'(BYTES_PER_BLOCK - 1));
    assign rd_en         = (mode_reg == ST_FLUSH) && (!rd_pend_reg || out_free);

    mxfp4_upper_ram u_ram (
        .clk     (clk),
        .wr_en   (s_fire && !is_scale),
        .wr_addr (4'(pos_reg - 5'd1)),
        .wr_data (s_axis_tdata[7:4]),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 5'd0;
            scale_reg   <= 8'd0;
            mode_reg    <= ST_STREAM;
            rd_idx_reg  <= 4'd0;
            rd_pend_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                ovalid_reg <= 1'b0;
            end
            if (s_fire)
            begin
                if (is_scale)
                begin
                    scale_reg <= s_axis_tdata;
                    pos_reg   <= 5'd1;
                end
                else
                begin
                    ovalid_reg <= 1'b1;
                    pos_reg    <= last_data ? 5'd0 : pos_reg + 5'd1;
                    if (last_data)
                    begin
                        mode_reg   <= ST_FLUSH;
                        rd_idx_reg <= 4'd0;
                    end
                end
            end
            if (rd_pend_reg && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd_pend_reg <= 1'b1;
                rd_idx_reg  <= rd_idx_reg + 4'd1;
                if (rd_idx_reg == 4'(HALF_ELEMS - 1))
                begin
                    mode_reg <= ST_STREAM;
                end
            end
            else if (rd_pend_reg && out_free)
            begin
                rd_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_elem_reg <= rd_idx_reg;
        end
        if (s_fire && !is_scale)
        begin
            odata_reg <= encode_product(scale_reg, s_axis_tdata[3:0]);
            oidx_reg  <= 5'(pos_reg - 5'd1);
        end
        else if (rd_pend_reg && out_free)
        begin
            odata_reg <= encode_product(scale_reg, rd_data);
            oidx_reg  <= {1'b1, rd_elem_reg};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = oidx_reg;
    assign m_axis_tlast  = (oidx_reg == 5'd31);

endmodule

FILE: design/mxfp4_checker.sv
// ----------------------------------------------------------------------------
// mxfp4_checker
// Port-level checks of the dequantizer, bound to the top level.
// ----------------------------------------------------------------------------
module mxfp4_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 5'd31)))
        else $error("tlast does not match element 31");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[4] && !m_axis_tlast
        |=> !m_axis_tvalid || m_axis_tuser == $past(m_axis_tuser) + 5'd1)
        else $error("flush elements out of order");
endmodule

bind mxfp4_block_dequantizer_core mxfp4_checker u_checker (.*);
